FILE: rtl/core/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg: shared types and constants of the integer to ASCII formatter
// Holds the format codes, the character constants and the control bundle that
// the top level hands to the binary to BCD converter.
// ----------------------------------------------------------------------------
package itaf_pkg;

  // Format selector carried in the low bits of in_tuser.
  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,  // signed decimal of the low 32 bits
    CMD_UDEC = 2'd1,  // unsigned decimal, 32 or 64 bits
    CMD_HEX  = 2'd2,  // upper-case hex, every digit
    CMD_BIN  = 2'd3   // binary, every bit
  } cmd_t;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NARROW_W   = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned COUNT_W    = 7;   // holds counts up to 64

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;  // '-'
  localparam logic [3:0]        DEC_TEN    = 4'd10;

  // Control bundle for the BCD converter; at most one action per cycle.
  typedef struct packed {
    logic clear;   // load all digits with zero
    logic dabble;  // add-3 correction, then shift in one binary bit
    logic bit_in;  // binary bit entering at the bottom on a dabble step
    logic pop;     // shift out the top digit, zero fill at the bottom
  } bcd_ctl_t;

endpackage

FILE: rtl/core/itaf_bcd_conv.sv
// ----------------------------------------------------------------------------
// itaf_bcd_conv: shift-and-add-3 binary to BCD converter
// Twenty BCD digits that take one binary bit per step, most significant bit
// first, and then give up their digits from the top one at a time.
// ----------------------------------------------------------------------------
module itaf_bcd_conv (
  input  logic                clk,
  input  itaf_pkg::bcd_ctl_t  ctl,
  output logic [3:0]          top_digit
);

  logic [itaf_pkg::BCD_W-1:0] bcd_r;
  logic [itaf_pkg::BCD_W-1:0] bcd_nxt;
  logic [itaf_pkg::BCD_W-1:0] adjusted;

  // Each digit of five or more gets three added before the doubling step.
  always_comb begin
    for (int d = 0; d < itaf_pkg::BCD_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        adjusted[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        adjusted[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    if (ctl.clear) begin
      bcd_nxt = '0;
    end else if (ctl.dabble) begin
      bcd_nxt = {adjusted[itaf_pkg::BCD_W-2:0], ctl.bit_in};
    end else if (ctl.pop) begin
      bcd_nxt = {bcd_r[itaf_pkg::BCD_W-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[itaf_pkg::BCD_W-1 -: 4];

endmodule

FILE: rtl/core/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit: number to ASCII character stream
// Formats one 64-bit value as signed decimal, unsigned decimal, upper-case
// hex or binary and sends the characters one per transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  -------------------------------------------------------
//  in_      slave      tdata: value[63:0]; tuser: command[1:0], wide[2]
//  out_     master     tdata: character[6:0], zero[7]; tuser: space_follows;
//                      tlast: final character of the number
//
// Hex and binary need no conversion: after the input transfer the block sends
// one character per cycle while the output is not stalled, 8 or 16 for hex and
// 32 or 64 for binary. Decimal first runs the value through a shared
// shift-and-add-3 unit, one bit per cycle (32 bits when narrow or signed, 64
// when wide), then drops leading zero digits one per cycle (up to 19), then
// sends the sign and the digits one per cycle while the output is not stalled.
// Dropped zeros and sent digits add up to twenty. in_tready is high only
// while no number is in progress; a stalled output simply holds the sender.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  input  logic [2:0]  in_tuser,   // [1:0] command, [2] wide
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] character, [7] zero
  output logic        out_tuser,  // [0] space_follows
  output logic        out_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,  // waiting for an input transfer
    ST_CONV,  // decimal: shifting bits into the BCD unit
    ST_SKIP,  // decimal: dropping leading zero digits
    ST_EMIT   // sending characters
  } state_t;

  localparam int unsigned VW = itaf_pkg::VALUE_W;
  localparam int unsigned NW = itaf_pkg::NARROW_W;
  localparam int unsigned CW = itaf_pkg::COUNT_W;

  state_t                        state_r, state_nxt;
  itaf_pkg::cmd_t                cmd_r, cmd_nxt;
  logic                          neg_r, neg_nxt;
  logic [VW-1:0]                 val_r, val_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;   // conversion bits left
  logic [CW-1:0]                 rem_r, rem_nxt;   // characters or digits left
  logic                          out_valid_r, out_valid_nxt;
  logic [itaf_pkg::CHAR_W-1:0]   char_r, char_nxt;
  logic                          space_r, space_nxt;
  logic                          last_r, last_nxt;

  itaf_pkg::bcd_ctl_t            bcd_ctl;
  logic [3:0]                    top_digit;

  // Input decode.
  itaf_pkg::cmd_t                in_cmd;
  logic                          in_wide;
  logic [NW-1:0]                 in_low;
  logic [NW-1:0]                 in_mag;
  logic [VW-1:0]                 in_unsigned;
  logic                          out_free;
  logic [3:0]                    nib;

  assign in_cmd      = itaf_pkg::cmd_t'(in_tuser[1:0]);
  assign in_wide     = in_tuser[2];
  assign in_low      = in_tdata[NW-1:0];
  // Two's complement negation; the most negative value maps onto 2^31 as
  // an unsigned magnitude, which is the right answer.
  assign in_mag      = in_low[NW-1] ? (~in_low + 1'b1) : in_low;
  // Narrow values sit at the top of the shift register so that the
  // most significant bit always leaves from bit 63.
  assign in_unsigned = in_wide ? in_tdata : {in_low, {NW{1'b0}}};

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign nib       = val_r[VW-1 -: 4];

  itaf_bcd_conv u_bcd (
    .clk       (clk),
    .ctl       (bcd_ctl),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    neg_nxt       = neg_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    char_nxt      = char_r;
    space_nxt     = space_r;
    last_nxt      = last_r;
    bcd_ctl       = '0;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_cmd;
          neg_nxt = 1'b0;
          val_nxt = in_unsigned;
          case (in_cmd)
            itaf_pkg::CMD_SDEC: begin
              neg_nxt       = in_low[NW-1];
              val_nxt       = {in_mag, {NW{1'b0}}};
              cnt_nxt       = CW'(NW);
              bcd_ctl.clear = 1'b1;
              state_nxt     = ST_CONV;
            end
            itaf_pkg::CMD_UDEC: begin
              cnt_nxt       = in_wide ? CW'(VW) : CW'(NW);
              bcd_ctl.clear = 1'b1;
              state_nxt     = ST_CONV;
            end
            itaf_pkg::CMD_HEX: begin
              rem_nxt   = in_wide ? CW'(VW / 4) : CW'(NW / 4);
              state_nxt = ST_EMIT;
            end
            default: begin
              rem_nxt   = in_wide ? CW'(VW) : CW'(NW);
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_CONV: begin
        bcd_ctl.dabble = 1'b1;
        bcd_ctl.bit_in = val_r[VW-1];
        val_nxt        = {val_r[VW-2:0], 1'b0};
        cnt_nxt        = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          rem_nxt   = CW'(itaf_pkg::BCD_DIGITS);
          state_nxt = ST_SKIP;
        end
      end

      ST_SKIP: begin
        // Zero itself keeps its last digit.
        if (top_digit == 4'd0 && rem_r != CW'(1)) begin
          bcd_ctl.pop = 1'b1;
          rem_nxt     = rem_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          space_nxt     = 1'b0;
          last_nxt      = 1'b0;
          if (neg_r) begin
            // The minus sign goes out ahead of the digits.
            char_nxt = itaf_pkg::CHAR_MINUS;
            neg_nxt  = 1'b0;
          end else begin
            last_nxt = (rem_r == CW'(1));
            rem_nxt  = rem_r - 1'b1;
            if (rem_r == CW'(1)) begin
              state_nxt = ST_IDLE;
            end
            case (cmd_r)
              itaf_pkg::CMD_HEX: begin
                if (nib >= itaf_pkg::DEC_TEN) begin
                  char_nxt = itaf_pkg::CHAR_A + {3'b000, nib} - {3'b000, itaf_pkg::DEC_TEN};
                end else begin
                  char_nxt = itaf_pkg::CHAR_ZERO + {3'b000, nib};
                end
                val_nxt = {val_r[VW-5:0], 4'b0000};
              end
              itaf_pkg::CMD_BIN: begin
                char_nxt  = itaf_pkg::CHAR_ZERO + {6'b000000, val_r[VW-1]};
                // Every eighth bit from the top; the bit count is a
                // multiple of eight, so this is where one remains mod 8.
                space_nxt = (rem_r[2:0] == 3'd1);
                val_nxt   = {val_r[VW-2:0], 1'b0};
              end
              default: begin
                char_nxt    = itaf_pkg::CHAR_ZERO + {3'b000, top_digit};
                bcd_ctl.pop = 1'b1;
              end
            endcase
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    val_r   <= val_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    char_r  <= char_nxt;
    space_r <= space_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, char_r};
  assign out_tuser  = space_r;
  assign out_tlast  = last_r;

endmodule

FILE: rtl/core/itaf_checker.sv
// ----------------------------------------------------------------------------
// itaf_checker: port-level checks for the integer to ASCII formatter
// Watches the top level's ports and flags changed held payloads, overlapping
// numbers, stray characters, misplaced space marks and a final minus sign.
// ----------------------------------------------------------------------------
module itaf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  // One number at a time: an accepted input closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a number is in progress");

  // Space marks occur only on binary digits.
  a_space_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'h30 || out_tdata == 8'h31)
    else $error("space mark on a non-binary character");

  // Every character is a digit, an upper-case hex letter or a minus sign.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'h30 && out_tdata <= 8'h39)
      || (out_tdata >= 8'h41 && out_tdata <= 8'h46) || out_tdata == 8'h2d)
    else $error("character outside the output set");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 8'h2d |-> !out_tlast)
    else $error("minus sign marked as final character");

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (.*);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the integer to ASCII formatter
// Sends numbers in all four formats, first from a directed table and then at
// random, with random gaps on both streams and one long output hold-off. Each
// received character is checked against the table's text or a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import itaf_pkg::*;

  localparam int RANDOM_ITEMS  = 136;
  localparam int PRESSURE_AT   = 30;       // numbers accepted before the hold-off
  localparam int PRESSURE_HOLD = 400;
  localparam int DRAIN_CYCLES  = 120;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              space;
    logic              last;
  } out_char_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] value;
    logic        wide;
  } number_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [63:0] value
  logic [2:0]  in_tuser = '0;   // [1:0] command, [2] wide
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [6:0] character, [7] zero
  logic        out_tuser;       // [0] space_follows
  logic        out_tlast;

  out_char_t   pending_chars[$];
  out_char_t   run_chars[$];
  number_row_t number_table[$];
  string       table_text[$];

  int errors = 0;
  int cycles = 0;
  int numbers_in = 0;
  int chars_checked = 0;
  int per_cmd[4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int hold_left = 0;
  int free_left = 0;
  int ready_roll;
  bit pressure_done = 1'b0;

  integer_to_ascii_formatter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still pending",
               cycles, pending_chars.size());
      $display("integer_to_ascii_formatter_unit verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  task automatic push_decimal(input logic [63:0] mag);
    logic [CHAR_W-1:0] digs [20];
    int                k;
    out_char_t         c;
    k = 0;
    do begin
      digs[k] = CHAR_ZERO + CHAR_W'(mag % 64'd10);
      k++;
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    while (k > 0) begin
      k--;
      c = {digs[k], 1'b0, 1'b0};
      run_chars.push_back(c);
    end
  endtask

  // Expected character run of one number, appended to pending_chars.
  task automatic format_number(input cmd_t cmd, input logic [63:0] value, input logic wide);
    logic [63:0] num;
    logic [31:0] low;
    logic [3:0]  nib;
    int          bits;
    out_char_t   c;
    num  = wide ? value : {32'd0, value[31:0]};
    bits = wide ? 64 : 32;
    run_chars.delete();
    case (cmd)
      CMD_SDEC: begin
        low = value[31:0];
        if (low[31]) begin
          run_chars.push_back({CHAR_MINUS, 1'b0, 1'b0});
          // Negating in 32 bits leaves the most negative value at 2^31.
          push_decimal({32'd0, 32'd0 - low});
        end else begin
          push_decimal({32'd0, low});
        end
      end
      CMD_UDEC: push_decimal(num);
      CMD_HEX: begin
        for (int sh = bits - 4; sh >= 0; sh -= 4) begin
          nib     = num[sh +: 4];
          c.ch    = (nib >= DEC_TEN) ? CHAR_A + CHAR_W'(nib - DEC_TEN) : CHAR_ZERO + CHAR_W'(nib);
          c.space = 1'b0;
          c.last  = 1'b0;
          run_chars.push_back(c);
        end
      end
      default: begin
        for (int i = 0; i < bits; i++) begin
          c.ch    = CHAR_ZERO + CHAR_W'(num[bits - 1 - i]);
          c.space = ((i + 1) % 8) == 0;
          c.last  = 1'b0;
          run_chars.push_back(c);
        end
      end
    endcase
    c = run_chars.pop_back();
    c.last = 1'b1;
    run_chars.push_back(c);
    foreach (run_chars[i]) pending_chars.push_back(run_chars[i]);
  endtask

  // Offers one number after a random gap and waits for its transfer. A
  // non-empty text is the expected run itself; otherwise the predictor runs.
  task automatic send_number(input cmd_t cmd, input logic [63:0] value, input logic wide,
                             input string text);
    int        gap;
    int        roll;
    byte       b;
    out_char_t c;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 50) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if ($urandom_range(0, 15) == 0) burst_left = 12;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= {wide, cmd};
    do @(posedge clk); while (!in_tready);
    numbers_in++;
    per_cmd[cmd]++;
    if (text.len() > 0) begin
      for (int i = 0; i < text.len(); i++) begin
        b       = text[i];
        c.ch    = b[CHAR_W-1:0];
        c.space = 1'b0;
        c.last  = (i == text.len() - 1);
        pending_chars.push_back(c);
      end
    end else begin
      format_number(cmd, value, wide);
    end
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    int          k;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: begin
        v = 64'($urandom_range(0, 999));
        if ($urandom_range(0, 1) == 1) v[63:32] = $urandom;
      end
      2: v = {$urandom, 32'h8000_0000 + 32'($urandom_range(0, 4)) - 32'd2};
      3: begin
        // Around a power of ten, where the digit count changes.
        k = $urandom_range(0, 19);
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      4: v = {($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0, ~32'($urandom_range(0, 3))};
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  // Output side: random stalls, ready stretches, and one long hold-off once
  // enough numbers have gone in so that the input side backs up.
  always @(posedge clk) begin
    if (!pressure_done && numbers_in >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left = PRESSURE_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      out_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 8) free_left = 30;
      else if (ready_roll < 20) hold_left = $urandom_range(1, 3);
      else if (ready_roll < 23) hold_left = $urandom_range(8, 20);
      out_tready <= (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    out_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("character 0x%02h with nothing pending", out_tdata));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_tdata[6:0] !== want.ch)
          flag_mismatch($sformatf("character 0x%02h, expected 0x%02h", out_tdata[6:0], want.ch));
        if (out_tdata[7] !== 1'b0)
          flag_mismatch("padding bit of out_tdata is not zero");
        if (out_tuser !== want.space)
          flag_mismatch($sformatf("space_follows %b, expected %b", out_tuser, want.space));
        if (out_tlast !== want.last)
          flag_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
      end
    end
  end

  task automatic add_row(input cmd_t cmd, input logic [63:0] value, input logic wide,
                         input string text);
    number_table.push_back({cmd, value, wide});
    table_text.push_back(text);
  endtask

  initial begin
    number_row_t row;
    cmd_t        cmd;

    add_row(CMD_SDEC, 64'h0000_0000_0000_0000, 1'b0, "0");
    add_row(CMD_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b0, "2147483647");
    add_row(CMD_SDEC, 64'h0000_0000_8000_0000, 1'b0, "-2147483648");
    add_row(CMD_SDEC, 64'h0000_0000_8000_0001, 1'b0, "-2147483647");
    add_row(CMD_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0, "-1");
    // Signed ignores the wide flag and the upper word.
    add_row(CMD_SDEC, 64'hFFFF_FFFF_8000_0000, 1'b1, "-2147483648");
    add_row(CMD_SDEC, 64'h1234_5678_0000_0001, 1'b1, "1");
    add_row(CMD_UDEC, 64'h0000_0000_0000_0000, 1'b0, "0");
    add_row(CMD_UDEC, 64'h0000_0000_0000_0000, 1'b1, "0");
    add_row(CMD_UDEC, 64'hFFFF_FFFF_0000_0000, 1'b0, "0");
    add_row(CMD_UDEC, 64'h0000_0000_0000_000A, 1'b0, "10");
    add_row(CMD_UDEC, 64'd999999999, 1'b0, "999999999");
    add_row(CMD_UDEC, 64'd1000000000, 1'b0, "1000000000");
    add_row(CMD_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b0, "4294967295");
    add_row(CMD_UDEC, 64'h8000_0000_0000_0000, 1'b1, "9223372036854775808");
    add_row(CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "18446744073709551615");
    add_row(CMD_HEX,  64'h0000_0000_0000_0000, 1'b0, "00000000");
    add_row(CMD_HEX,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "FFFFFFFFFFFFFFFF");
    add_row(CMD_HEX,  64'h0123_4567_89AB_CDEF, 1'b1, "0123456789ABCDEF");
    add_row(CMD_HEX,  64'h0123_4567_89AB_CDEF, 1'b0, "89ABCDEF");
    add_row(CMD_BIN,  64'h0000_0000_0000_0000, 1'b0, "");
    add_row(CMD_BIN,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "");
    add_row(CMD_BIN,  64'h5A5A_5A5A_A5A5_A5A5, 1'b0, "");
    add_row(CMD_BIN,  64'h8000_0000_0000_0001, 1'b1, "");

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (number_table[i]) begin
      row = number_table[i];
      send_number(row.cmd, row.value, row.wide, table_text[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cmd = cmd_t'($urandom_range(0, 3));
      send_number(cmd, pick_value(), 1'($urandom_range(0, 1)), "");
    end
    in_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d numbers: %0d signed, %0d unsigned, %0d hex, %0d binary.",
             numbers_in, per_cmd[CMD_SDEC], per_cmd[CMD_UDEC], per_cmd[CMD_HEX],
             per_cmd[CMD_BIN]);
    $display("Checked %0d characters, with a %0d-cycle output hold-off; %0d mismatches.",
             chars_checked, PRESSURE_HOLD, errors);
    if (errors == 0) begin
      $display("integer_to_ascii_formatter_unit verification clean");
    end else begin
      $display("integer_to_ascii_formatter_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: integer_to_ascii_formatter_unit.f
rtl/core/itaf_pkg.sv
rtl/core/itaf_bcd_conv.sv
rtl/core/integer_to_ascii_formatter_unit.sv
rtl/core/itaf_checker.sv
dv/tb_top.sv
